[design/sequence_match_ranker_top_defines.svh]
`ifndef SEQUENCE_MATCH_RANKER_TOP_DEFINES_SVH
`define SEQUENCE_MATCH_RANKER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SMR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property whose consequence must hold in the cycle after the trigger.
`define SMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/smr_pkg.sv]
package smr_pkg;

    localparam logic [1:0] MODE_NEW  = 2'd0;
    localparam logic [1:0] MODE_SYM  = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // register select on paddr[2]
    localparam logic REG_SEQ_LENGTH      = 1'b0;
    localparam logic REG_REFERENCE_INDEX = 1'b1;

    localparam logic [4:0] SEQ_LENGTH_RESET = 5'd20;
    localparam logic [4:0] REF_INDEX_RESET  = 5'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] name_head;
        logic [63:0] name_tail;
        logic [7:0]  symbol;
    } in_t;

    typedef struct packed {
        logic [15:0] out_name_head;
        logic [63:0] out_name_tail;
        logic [4:0]  match_count;
        logic        is_reference;
        logic        last;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_REF_RD,
        S_REF_LATCH,
        S_CNT_RD,
        S_CNT_ACC,
        S_SEL_RD,
        S_SEL_CMP,
        S_SEL_END
    } state_t;

    typedef struct packed {
        logic new_rec;
        logic full_rec;
        logic add_sym;
        logic clr_step;
        logic run_init;
        logic ref_rd;
        logic ref_latch;
        logic cnt_rd;
        logic cnt_acc;
        logic sel_init;
        logic sel_cmp;
        logic sel_end;
    } cmd_t;

    typedef struct packed {
        logic room;
        logic run_ok;
        logic clr_done;
        logic pos_end;
        logic cnt_last;
        logic sel_last;
        logic found;
    } sts_t;

endpackage

[design/smr_ctrl.sv]
`include "sequence_match_ranker_top_defines.svh"

module smr_ctrl
    import smr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_NEW && sts.room)
                begin
                    state_next = S_CLEAR;
                end
                else if (accept && mode == MODE_RUN && sts.run_ok)
                begin
                    state_next = S_REF_RD;
                end
            end
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REF_RD:    state_next = S_REF_LATCH;
            S_REF_LATCH: state_next = S_CNT_RD;
            S_CNT_RD:
            begin
                if (!sts.pos_end)
                begin
                    state_next = S_CNT_ACC;
                end
                else if (sts.cnt_last)
                begin
                    state_next = S_SEL_RD;
                end
            end
            S_CNT_ACC:   state_next = S_CNT_RD;
            S_SEL_RD:    state_next = S_SEL_CMP;
            S_SEL_CMP:
            begin
                if (sts.sel_last)
                begin
                    state_next = S_SEL_END;
                end
                else
                begin
                    state_next = S_SEL_RD;
                end
            end
            S_SEL_END:
            begin
                if (sts.found)
                begin
                    state_next = S_SEL_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.new_rec  = accept && mode == MODE_NEW && sts.room;
                cmd.full_rec = accept && mode == MODE_NEW && !sts.room;
                cmd.add_sym  = accept && mode == MODE_SYM;
                cmd.run_init = accept && mode == MODE_RUN && sts.run_ok;
            end
            S_CLEAR:     cmd.clr_step = 1'b1;
            S_REF_RD:    cmd.ref_rd = 1'b1;
            S_REF_LATCH: cmd.ref_latch = 1'b1;
            S_CNT_RD:
            begin
                cmd.cnt_rd   = 1'b1;
                cmd.sel_init = sts.pos_end && sts.cnt_last;
            end
            S_CNT_ACC:   cmd.cnt_acc = 1'b1;
            S_SEL_CMP:   cmd.sel_cmp = 1'b1;
            S_SEL_END:   cmd.sel_end = 1'b1;
            default:     cmd = '0;
        endcase
    end

    `SMR_ASSERT_NEXT(a_bad_ref_stays_idle,
        accept && mode == MODE_RUN && !sts.run_ok, state_reg == S_IDLE,
        "rejected run left idle")
    `SMR_ASSERT_NEXT(a_clear_returns_idle,
        state_reg == S_CLEAR && sts.clr_done, state_reg == S_IDLE,
        "row clear did not finish")
    `SMR_ASSERT_NEXT(a_run_ends_idle,
        state_reg == S_SEL_END && !sts.found, state_reg == S_IDLE,
        "run did not end after last selection")

endmodule

[design/smr_datapath.sv]
`include "sequence_match_ranker_top_defines.svh"

module smr_datapath
    import smr_pkg::*;
#(
    parameter int MAX_RECORDS = 20,
    parameter int MAX_SYMBOLS = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        item,
    input  cmd_t       cmd,
    input  logic [4:0] seq_length,
    input  logic [4:0] reference_index,
    output sts_t       sts,
    output logic       strobe,
    output out_t       result
);

    localparam int IW    = $clog2(MAX_RECORDS);
    localparam int RW    = $clog2(MAX_RECORDS + 1);
    localparam int SIW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int PW    = $clog2(MAX_SYMBOLS + 1);
    localparam int CW    = PW;
    localparam int DEPTH = MAX_RECORDS * MAX_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] sym_addr(input logic [IW-1:0] row,
                                               input logic [SIW-1:0] col);
        return AW'(row) * AW'(MAX_SYMBOLS) + AW'(col);
    endfunction

    // count descending, then name ascending, then load order
    function automatic logic ranks_before(input logic [CW-1:0] ca,
                                          input logic [79:0]   na,
                                          input logic [IW-1:0] ia,
                                          input logic [CW-1:0] cb,
                                          input logic [79:0]   nb,
                                          input logic [IW-1:0] ib);
        if (ca != cb)
        begin
            return ca > cb;
        end
        if (na != nb)
        begin
            return na < nb;
        end
        return ia < ib;
    endfunction

    logic [7:0]  sym_mem  [DEPTH];
    logic [79:0] name_mem [MAX_RECORDS];
    logic [CW-1:0] cnt_mem [MAX_RECORDS];

    // control state
    logic [RW-1:0]  rec_cnt_reg;
    logic [PW-1:0]  sym_pos_reg;
    logic [SIW-1:0] clr_pos_reg;
    logic [IW-1:0]  x_reg;
    logic [PW-1:0]  pos_reg;
    logic [CW-1:0]  sum_reg;
    logic [IW-1:0]  y_reg;
    logic           found_reg;
    logic           have_last_reg;
    logic           strobe_reg;

    // payload
    logic [IW-1:0]  clr_row_reg;
    logic [IW-1:0]  ref_reg;
    logic [PW-1:0]  len_reg;
    logic [79:0]    ref_name_reg;
    logic [7:0]     sym_a_reg;
    logic [7:0]     sym_b_reg;
    logic [79:0]    name_rd_reg;
    logic [CW-1:0]  cnt_rd_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic [79:0]    best_name_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [CW-1:0]  lk_cnt_reg;
    logic [79:0]    lk_name_reg;
    logic [IW-1:0]  lk_idx_reg;
    logic [CW-1:0]  pend_cnt_reg;
    logic [79:0]    pend_name_reg;
    logic           pend_isref_reg;
    out_t           res_reg;

    logic [PW-1:0]  used_len;
    logic           sym_ok;
    logic           sym_we;
    logic [AW-1:0]  sym_waddr;
    logic [7:0]     sym_wdata;
    logic [IW-1:0]  name_addr;
    logic           pos_end;
    logic           qualifies;
    logic           emit;

    always_comb
    begin
        if (32'(seq_length) >= MAX_SYMBOLS)
        begin
            used_len = PW'(MAX_SYMBOLS);
        end
        else
        begin
            used_len = PW'(seq_length);
        end
    end

    assign sym_ok    = (rec_cnt_reg != '0) && (sym_pos_reg < used_len);
    assign sym_we    = cmd.clr_step || (cmd.add_sym && sym_ok);
    assign sym_waddr = cmd.clr_step ? sym_addr(clr_row_reg, clr_pos_reg)
                     : sym_addr(IW'(rec_cnt_reg - RW'(1)), sym_pos_reg[SIW-1:0]);
    assign sym_wdata = cmd.clr_step ? 8'd0 : item.symbol;
    assign name_addr = cmd.ref_rd ? ref_reg : y_reg;
    assign pos_end   = (pos_reg >= len_reg);

    assign qualifies = (!have_last_reg
                        || ranks_before(lk_cnt_reg, lk_name_reg, lk_idx_reg,
                                        cnt_rd_reg, name_rd_reg, y_reg))
                    && (!found_reg
                        || ranks_before(cnt_rd_reg, name_rd_reg, y_reg,
                                        best_cnt_reg, best_name_reg, best_idx_reg));

    // a record sharing the reference name is never emitted after it
    assign emit = cmd.sel_end && (!found_reg || best_name_reg != ref_name_reg);

    always_comb
    begin
        sts          = '0;
        sts.room     = (32'(rec_cnt_reg) < MAX_RECORDS);
        sts.run_ok   = (reference_index != 5'd0)
                    && (32'(reference_index) <= 32'(rec_cnt_reg));
        sts.clr_done = (clr_pos_reg == SIW'(MAX_SYMBOLS - 1));
        sts.pos_end  = pos_end;
        sts.cnt_last = (RW'(x_reg) == rec_cnt_reg - RW'(1));
        sts.sel_last = (RW'(y_reg) == rec_cnt_reg - RW'(1));
        sts.found    = found_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        sym_a_reg <= sym_mem[sym_addr(ref_reg, pos_reg[SIW-1:0])];
        sym_b_reg <= sym_mem[sym_addr(x_reg, pos_reg[SIW-1:0])];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_rec)
        begin
            name_mem[rec_cnt_reg[IW-1:0]] <= {item.name_head, item.name_tail};
        end
        name_rd_reg <= name_mem[name_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd && pos_end)
        begin
            cnt_mem[x_reg] <= (x_reg == ref_reg) ? '0 : sum_reg;
        end
        cnt_rd_reg <= cnt_mem[y_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_cnt_reg   <= '0;
            sym_pos_reg   <= '0;
            clr_pos_reg   <= '0;
            x_reg         <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            y_reg         <= '0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
            if (cmd.new_rec)
            begin
                rec_cnt_reg <= rec_cnt_reg + RW'(1);
                sym_pos_reg <= '0;
                clr_pos_reg <= '0;
            end
            if (cmd.full_rec)
            begin
                sym_pos_reg <= PW'(MAX_SYMBOLS);
            end
            if (cmd.add_sym && sym_ok)
            begin
                sym_pos_reg <= sym_pos_reg + PW'(1);
            end
            if (cmd.clr_step)
            begin
                clr_pos_reg <= clr_pos_reg + SIW'(1);
            end
            if (cmd.run_init)
            begin
                x_reg   <= '0;
                pos_reg <= '0;
                sum_reg <= '0;
            end
            if (cmd.cnt_rd && pos_end)
            begin
                x_reg   <= x_reg + IW'(1);
                pos_reg <= '0;
                sum_reg <= '0;
            end
            if (cmd.cnt_acc)
            begin
                pos_reg <= pos_reg + PW'(1);
                if (sym_a_reg == sym_b_reg)
                begin
                    sum_reg <= sum_reg + CW'(1);
                end
            end
            if (cmd.sel_init)
            begin
                y_reg         <= '0;
                found_reg     <= 1'b0;
                have_last_reg <= 1'b0;
            end
            if (cmd.sel_cmp)
            begin
                y_reg <= sts.sel_last ? '0 : y_reg + IW'(1);
                if (qualifies)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.sel_end)
            begin
                found_reg <= 1'b0;
                if (found_reg)
                begin
                    have_last_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.new_rec)
        begin
            clr_row_reg <= rec_cnt_reg[IW-1:0];
        end
        if (cmd.run_init)
        begin
            ref_reg <= IW'(reference_index - 5'd1);
            len_reg <= used_len;
        end
        if (cmd.ref_latch)
        begin
            ref_name_reg <= name_rd_reg;
        end
        if (cmd.sel_init)
        begin
            pend_name_reg  <= ref_name_reg;
            pend_cnt_reg   <= '0;
            pend_isref_reg <= 1'b1;
        end
        if (cmd.sel_cmp && qualifies)
        begin
            best_cnt_reg  <= cnt_rd_reg;
            best_name_reg <= name_rd_reg;
            best_idx_reg  <= y_reg;
        end
        if (emit)
        begin
            res_reg.out_name_head <= pend_name_reg[79:64];
            res_reg.out_name_tail <= pend_name_reg[63:0];
            res_reg.match_count   <= 5'(pend_cnt_reg);
            res_reg.is_reference  <= pend_isref_reg;
            res_reg.last          <= !found_reg;
        end
        if (cmd.sel_end && found_reg)
        begin
            lk_cnt_reg  <= best_cnt_reg;
            lk_name_reg <= best_name_reg;
            lk_idx_reg  <= best_idx_reg;
            if (emit)
            begin
                pend_name_reg  <= best_name_reg;
                pend_cnt_reg   <= best_cnt_reg;
                pend_isref_reg <= 1'b0;
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    `SMR_ASSERT_ALWAYS(a_rec_cnt_bound, 32'(rec_cnt_reg) <= MAX_RECORDS,
        "record count past capacity")
    `SMR_ASSERT_ALWAYS(a_sum_bound, sum_reg <= len_reg || !cmd.cnt_rd,
        "match sum past sequence length")
    `SMR_ASSERT_NEXT(a_final_transfer, cmd.sel_end && !found_reg,
        strobe_reg && res_reg.last, "run ended without final transfer")

endmodule

[design/sequence_match_ranker_top.sv]
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------
// command   | in        | start, busy            | item   (in_t)
// result    | out       | strobe                 | result (out_t)
// config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
// Append symbol does not leave idle; new record then clears its symbol row. A run
// first computes the match count of each record, then ranks the records; each
// ranking pass scans the record store through one registered read port and
// yields at most one transfer.
// rst_n clears the record count and control; stores hold garbage until written.
// The result side takes each transfer in its strobe cycle and cannot stall.
module sequence_match_ranker_top
    import smr_pkg::*;
#(
    parameter int MAX_RECORDS = 20,
    parameter int MAX_SYMBOLS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  in_t         item,
    output logic        strobe,
    output out_t        result
);

    logic [4:0] seq_length_reg;
    logic [4:0] ref_index_reg;
    cmd_t       cmd;
    sts_t       sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= SEQ_LENGTH_RESET;
            ref_index_reg  <= REF_INDEX_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_SEQ_LENGTH:      seq_length_reg <= pwdata[4:0];
                REG_REFERENCE_INDEX: ref_index_reg  <= pwdata[4:0];
                default:             seq_length_reg <= seq_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SEQ_LENGTH:      prdata = {27'd0, seq_length_reg};
            REG_REFERENCE_INDEX: prdata = {27'd0, ref_index_reg};
            default:             prdata = '0;
        endcase
    end

    smr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    smr_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .cmd             (cmd),
        .seq_length      (seq_length_reg),
        .reference_index (ref_index_reg),
        .sts             (sts),
        .strobe          (strobe),
        .result          (result)
    );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import smr_pkg::*;

    localparam int NREC    = 20;
    localparam int NSYM    = 20;
    localparam int SETTLE  = 64;
    localparam int N_ITEMS = 470;

    typedef struct {
        in_t  it;
        int   n_typed;   // -1: predicted, else number of typed results
        out_t typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    in_t         item;
    logic        strobe;
    out_t        result;

    // predictor state
    logic [4:0]  len_cfg;
    logic [4:0]  ref_cfg;
    int          rec_total;
    int          sym_pos;
    logic [15:0] head_mem [NREC];
    logic [63:0] tail_mem [NREC];
    logic [7:0]  sym_mem  [NREC][NSYM];

    out_t        pending_ranking [$];
    stim_row_t   rows [$];
    int          errors;
    int          items_done;
    int          results_seen;
    int          runs_done;
    int          idle_pct;

    sequence_match_ranker_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("** sequence_match_ranker_top: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // ranks record a before record b
    function automatic bit ranks_ahead(int a, int b, int cnt []);
        if (cnt[a] != cnt[b])
            return cnt[a] > cnt[b];
        return {head_mem[a], tail_mem[a]} < {head_mem[b], tail_mem[b]};
    endfunction

    function automatic void rank_by_similarity(in_t it);
        int   cnt [] = new[NREC];
        int   ord [NREC];
        int   refi;
        int   len;
        int   cur;
        int   j;
        out_t o;
        case (it.mode)
            MODE_NEW:
            begin
                if (rec_total < NREC)
                begin
                    head_mem[rec_total] = it.name_head;
                    tail_mem[rec_total] = it.name_tail;
                    for (int i = 0; i < NSYM; i++)
                        sym_mem[rec_total][i] = 8'h00;
                    rec_total++;
                    sym_pos = 0;
                end
                else
                    sym_pos = NSYM;
            end
            MODE_SYM:
            begin
                len = (len_cfg < NSYM) ? len_cfg : NSYM;
                if (rec_total > 0 && sym_pos < len)
                begin
                    sym_mem[rec_total - 1][sym_pos] = it.symbol;
                    sym_pos++;
                end
            end
            MODE_RUN:
            begin
                if (ref_cfg == 0 || ref_cfg > rec_total)
                    return;
                refi = ref_cfg - 1;
                len = (len_cfg < NSYM) ? len_cfg : NSYM;
                for (int x = 0; x < rec_total; x++)
                begin
                    cnt[x] = 0;
                    if (x != refi)
                        for (int i = 0; i < len; i++)
                            if (sym_mem[refi][i] == sym_mem[x][i])
                                cnt[x]++;
                end
                for (int i = 0; i < NREC; i++)
                    ord[i] = i;
                for (int i = 1; i < rec_total; i++)
                begin
                    cur = ord[i];
                    j = i;
                    while (j > 0 && ranks_ahead(cur, ord[j - 1], cnt))
                    begin
                        ord[j] = ord[j - 1];
                        j--;
                    end
                    ord[j] = cur;
                end
                o = '{head_mem[refi], tail_mem[refi], 5'd0, 1'b1, 1'b0};
                pending_ranking.push_back(o);
                for (int i = 0; i < rec_total; i++)
                begin
                    cur = ord[i];
                    if (head_mem[cur] == head_mem[refi] && tail_mem[cur] == tail_mem[refi])
                        continue;
                    o = '{head_mem[cur], tail_mem[cur], cnt[cur][4:0], 1'b0, 1'b0};
                    pending_ranking.push_back(o);
                end
                pending_ranking[pending_ranking.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // hold the item until the block takes it
    task automatic issue(in_t it, int n_typed = -1, out_t typed = '0);
        start <= 1'b1;
        item  <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (n_typed < 0)
            rank_by_similarity(it);
        else
        begin
            int before_n;
            before_n = pending_ranking.size();
            rank_by_similarity(it);
            while (pending_ranking.size() > before_n)
                void'(pending_ranking.pop_back());
            if (n_typed > 0)
                pending_ranking.push_back(typed);
        end
        items_done++;
        if (it.mode == MODE_RUN)
            runs_done++;
        idle_pct = ((items_done / 40) % 4 == 1) ? 53 : ((items_done / 40) % 4 == 3) ? 22 : 0;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_ranking.size() > 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {REG_SEQ_LENGTH, 2'b00})
            len_cfg = value;
        else
            ref_cfg = value;
    endtask

    task automatic configure(logic [4:0] len, logic [4:0] refv);
        drain();
        write_reg({REG_SEQ_LENGTH, 2'b00}, len);
        write_reg({REG_REFERENCE_INDEX, 2'b00}, refv);
        @(posedge clk);
    endtask

    function automatic stim_row_t mk(logic [1:0] m, logic [15:0] h, logic [63:0] t,
                                     logic [7:0] s, int n = -1);
        stim_row_t r;
        r.it      = '{m, h, t, s};
        r.n_typed = n;
        r.typed   = '0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            out_t want;
            results_seen++;
            if (pending_ranking.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = pending_ranking.pop_front();
                if (result.out_name_head !== want.out_name_head)
                    report_mismatch($sformatf("name_head %h want %h",
                        result.out_name_head, want.out_name_head));
                if (result.out_name_tail !== want.out_name_tail)
                    report_mismatch($sformatf("name_tail %h want %h",
                        result.out_name_tail, want.out_name_tail));
                if (result.match_count !== want.match_count)
                    report_mismatch($sformatf("match_count %0d want %0d",
                        result.match_count, want.match_count));
                if (result.is_reference !== want.is_reference)
                    report_mismatch($sformatf("is_reference %b want %b",
                        result.is_reference, want.is_reference));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %b want %b", result.last, want.last));
            end
        end
    end

    initial
    begin
        stim_row_t   r;
        in_t         it;
        logic [15:0] h;
        logic [63:0] t;
        int          pick;
        int          nsym;
        int          plan_idx;
        logic [4:0]  plan_len [6] = '{5'd0, 5'd20, 5'd3, 5'd1, 5'd12, 5'd7};
        logic [4:0]  plan_ref [6] = '{5'd2, 5'd20, 5'd1, 5'd3, 5'd5, 5'd1};

        errors = 0;
        items_done = 0;
        results_seen = 0;
        runs_done = 0;
        idle_pct = 0;
        plan_idx = 0;
        len_cfg = SEQ_LENGTH_RESET;
        ref_cfg = REF_INDEX_RESET;
        rec_total = 0;
        sym_pos = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        item = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no record, stray symbol, unused mode, extremes, duplicate name
        rows.push_back(mk(MODE_RUN, 16'h0, 64'h0, 8'h0, 0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'hAA, 0));
        rows.push_back(mk(2'd3, 16'hFFFF, '1, 8'hFF, 0));
        rows.push_back(mk(MODE_NEW, 16'hFFFF, '1, 8'h00, 0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'hFF, 0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'h00, 0));
        r = mk(MODE_RUN, 16'h0, 64'h0, 8'h0, 1);
        r.typed = '{16'hFFFF, '1, 5'd0, 1'b1, 1'b1};
        rows.push_back(r);
        rows.push_back(mk(MODE_NEW, 16'h0000, 64'h0, 8'h0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'hFF));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'h01));
        rows.push_back(mk(MODE_NEW, 16'hFFFF, '1, 8'h0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'hFF));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'h00));
        rows.push_back(mk(MODE_NEW, 16'h0000, 64'h1, 8'h0));
        rows.push_back(mk(MODE_SYM, 16'h0, 64'h0, 8'h55));
        rows.push_back(mk(MODE_RUN, 16'h0, 64'h0, 8'h0));
        rows.push_back(mk(MODE_NEW, 16'h8000, 64'h8000_0000_0000_0000, 8'h0));
        rows.push_back(mk(MODE_RUN, 16'h0, 64'h0, 8'h0));
        foreach (rows[i])
            issue(rows[i].it, rows[i].n_typed, rows[i].typed);

        while (items_done < N_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                it = '{2'($urandom_range(3)), 16'($urandom), {$urandom, $urandom},
                       8'($urandom)};
                if (it.mode == MODE_RUN || it.mode == MODE_NEW)
                    it.mode = 2'd3;
                issue(it);
            end
            else if (pick < ((rec_total == NREC) ? 40 : 16))
            begin
                if (plan_idx < 6)
                begin
                    configure(plan_len[plan_idx], plan_ref[plan_idx]);
                    plan_idx++;
                end
                else if ($urandom_range(1))
                    configure(5'($urandom_range(20)), 5'($urandom_range(20, 1)));
                it = '{MODE_RUN, 16'($urandom), {$urandom, $urandom}, 8'($urandom)};
                issue(it);
            end
            else
            begin
                h = 16'($urandom);
                t = {$urandom, $urandom};
                if (rec_total > 0 && $urandom_range(99) < 40)
                begin
                    pick = $urandom_range(rec_total - 1);
                    h = head_mem[pick];
                    if ($urandom_range(1))
                        t = tail_mem[pick];
                end
                issue('{MODE_NEW, h, t, 8'($urandom)});
                nsym = $urandom_range(len_cfg + 2);
                for (int k = 0; k < nsym; k++)
                begin
                    it = '{MODE_SYM, 16'($urandom), {$urandom, $urandom},
                           ($urandom_range(99) < 75) ? 8'($urandom_range(3)) : 8'($urandom)};
                    issue(it);
                end
            end
        end

        drain();
        $display("run covered %0d accepted items, %0d compute requests, %0d results checked",
                 items_done, runs_done, results_seen);
        $display("records loaded: %0d, mismatches: %0d", rec_total, errors);
        if (errors == 0 && pending_ranking.size() == 0)
            $display("** sequence_match_ranker_top: PASSED **");
        else
            $display("** sequence_match_ranker_top: FAILED **");
        $finish;
    end

endmodule

[sequence_match_ranker_top.f]
+incdir+design
design/smr_pkg.sv
design/smr_ctrl.sv
design/smr_datapath.sv
design/sequence_match_ranker_top.sv
verif/testbench.sv
